[rtl/rwt_pkg.sv]
`timescale 1ns / 1ps

package rwt_pkg;

  // Table geometry
  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int STAMP_W    = 32;

  // Command queue between front and back
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QFILL_BITS = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ABSENT   = 2'd1,
    ST_FULL     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [STAMP_W-1:0] stamp;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

[rtl/rwt_if.sv]
`timescale 1ns / 1ps

interface rwt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] stamp;

  modport source (output valid, output operation, output stamp, input ready);
  modport sink   (input valid, input operation, input stamp, output ready);
endinterface

interface rwt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] watermark;
  logic [1:0]  status;

  modport source (output valid, output watermark, output status, input ready);
  modport sink   (input valid, input watermark, input status, output ready);
endinterface

[rtl/read_timestamp_watermark_tracker_top.sv]
`timescale 1ns / 1ps

// Read-timestamp watermark tracker. Each req item (add, remove or update
// commit) yields exactly one rsp item carrying the watermark after that
// operation and a status code. A front end queues up to two items; the back
// end applies one at a time to a table of ENTRIES (stamp, count) slots. An
// item that leaves the table and commit stamp unchanged (dropped add, absent
// remove, unused code) is answered in the cycle after it leaves the queue;
// any other item first runs the minimum search, which walks the table one
// slot per cycle, and its result is registered at the end of the search. A
// result waits in the output register while the queue keeps taking items.
module read_timestamp_watermark_tracker_top
  import rwt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  rwt_req_if.sink    req,
  rwt_rsp_if.source  rsp
);

  cmd_head_t head;
  logic      pop;

  rwt_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .pop  (pop),
    .head (head)
  );

  rwt_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule

[rtl/rwt_front.sv]
`timescale 1ns / 1ps

module rwt_front
  import rwt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  rwt_req_if.sink    req,
  input  logic       pop,
  output cmd_head_t  head
);

  cmd_t                  queue [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QFILL_BITS-1:0] fill;
  logic                  push;
  cmd_t                  cmd_in;

  // Classify the incoming operation code
  always_comb begin
    cmd_in.stamp = req.stamp;
    case (req.operation)
      OP_ADD:    cmd_in.op = OP_ADD;
      OP_REMOVE: cmd_in.op = OP_REMOVE;
      OP_UPDATE: cmd_in.op = OP_UPDATE;
      default:   cmd_in.op = OP_NOP;
    endcase
  end

  assign req.ready = (fill != QFILL_BITS'(QDEPTH));
  assign push      = req.valid && req.ready;

  assign head.valid = (fill != '0);
  assign head.cmd   = queue[rd_ptr];

  // Store accepted items
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + QFILL_BITS'(1);
        2'b01:   fill <= fill - QFILL_BITS'(1);
        default: fill <= fill;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QFILL_BITS'(QDEPTH))
    else $error("queue fill above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != '0)
    else $error("pop from empty queue");

endmodule

[rtl/rwt_back.sv]
`timescale 1ns / 1ps

module rwt_back
  import rwt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_head_t  head,
  output logic       pop,
  rwt_rsp_if.source  rsp
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(ENTRIES - 1);

  state_t                  state;
  logic [STAMP_W-1:0]      stamp_mem [ENTRIES];
  logic [COUNT_BITS-1:0]   count [ENTRIES];
  logic [STAMP_W-1:0]      commit_stamp;
  logic [STAMP_W-1:0]      watermark;
  logic [IDX_BITS-1:0]     scan_idx;
  logic [STAMP_W-1:0]      best;
  logic                    any;
  status_t                 pend_status;
  status_t                 out_status;
  logic                    out_valid;

  logic                    hit_any;
  logic [IDX_BITS-1:0]     hit_idx;
  logic                    free_any;
  logic [IDX_BITS-1:0]     free_idx;
  logic                    cand;
  logic [STAMP_W-1:0]      scan_stamp;

  // Match and free-slot search, lowest index wins
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (count[i] != '0 && stamp_mem[i] == head.cmd.stamp) begin
        hit_any = 1'b1;
        hit_idx = IDX_BITS'(i);
      end
      if (count[i] == '0) begin
        free_any = 1'b1;
        free_idx = IDX_BITS'(i);
      end
    end
  end

  assign pop = (state == S_IDLE) && head.valid && !out_valid;

  // One entry per cycle of the minimum scan
  assign scan_stamp = stamp_mem[scan_idx];
  assign cand       = (count[scan_idx] != '0) && (!any || scan_stamp < best);

  assign rsp.valid     = out_valid;
  assign rsp.watermark = watermark;
  assign rsp.status    = out_status;

  // Stamp store has no reset
  always_ff @(posedge clk) begin
    if (pop && head.cmd.op == OP_ADD && !hit_any && free_any) begin
      stamp_mem[free_idx] <= head.cmd.stamp;
    end
  end

  // Apply commands, run the scan, hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      for (int i = 0; i < ENTRIES; i++) begin
        count[i] <= '0;
      end
      commit_stamp <= '0;
      watermark    <= '0;
      scan_idx     <= '0;
      best         <= '0;
      any          <= 1'b0;
      pend_status  <= ST_OK;
      out_status   <= ST_OK;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          scan_idx <= '0;
          any      <= 1'b0;
          if (pop) begin
            case (head.cmd.op)
              OP_ADD: begin
                if (hit_any) begin
                  if (count[hit_idx] == COUNT_MAX) begin
                    out_status <= ST_OVERFLOW;
                    out_valid  <= 1'b1;
                  end else begin
                    count[hit_idx] <= count[hit_idx] + COUNT_BITS'(1);
                    pend_status    <= ST_OK;
                    state          <= S_SCAN;
                  end
                end else if (!free_any) begin
                  out_status <= ST_FULL;
                  out_valid  <= 1'b1;
                end else begin
                  count[free_idx] <= COUNT_BITS'(1);
                  pend_status     <= ST_OK;
                  state           <= S_SCAN;
                end
              end
              OP_REMOVE: begin
                if (hit_any) begin
                  count[hit_idx] <= count[hit_idx] - COUNT_BITS'(1);
                  pend_status    <= ST_OK;
                  state          <= S_SCAN;
                end else begin
                  out_status <= ST_ABSENT;
                  out_valid  <= 1'b1;
                end
              end
              OP_UPDATE: begin
                commit_stamp <= head.cmd.stamp;
                pend_status  <= ST_OK;
                state        <= S_SCAN;
              end
              default: begin
                out_status <= ST_OK;
                out_valid  <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (cand) begin
            best <= scan_stamp;
            any  <= 1'b1;
          end
          if (scan_idx == LAST_IDX) begin
            if (cand) begin
              watermark <= scan_stamp;
            end else if (any) begin
              watermark <= best;
            end else begin
              watermark <= commit_stamp;
            end
            out_status <= pend_status;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            scan_idx <= scan_idx + IDX_BITS'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_scan_no_result: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !out_valid)
    else $error("result shown during scan");

  a_scan_commit_stable: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |=> $stable(commit_stamp))
    else $error("commit stamp changed during scan");

  a_result_watermark_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |=> $stable(watermark))
    else $error("watermark changed while result pending");

endmodule

[tb/tb_read_timestamp_watermark_tracker_top.sv]
`timescale 1ns / 1ps

module tb_read_timestamp_watermark_tracker_top;
  import rwt_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int CALM_ITEMS    = 300;
  localparam int DRAIN_PERIOD  = 250;
  localparam int SETTLE_CYCLES = 4 * ENTRIES;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [STAMP_W-1:0] watermark;
    logic [1:0]         status;
  } tracker_result_t;

  // Mirror of the read-stamp table plus the queue of watermark results owed
  class watermark_scoreboard;
    logic [STAMP_W-1:0]    slot_stamp [ENTRIES];
    logic [COUNT_BITS-1:0] slot_count [ENTRIES];
    logic [STAMP_W-1:0]    commit_stamp;
    logic [STAMP_W-1:0]    watermark;
    tracker_result_t       expected_q [$];
    int                    errors;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_stamp[i] = '0;
        slot_count[i] = '0;
      end
      commit_stamp = '0;
      watermark    = '0;
      errors       = 0;
    endfunction

    function int find_stamp(logic [STAMP_W-1:0] stamp);
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_count[i] != 0 && slot_stamp[i] == stamp) return i;
      end
      return -1;
    endfunction

    function int first_free();
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_count[i] == 0) return i;
      end
      return -1;
    endfunction

    function int live_slots();
      int n;
      n = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_count[i] != 0) n++;
      end
      return n;
    endfunction

    // Return the stamp of a randomly chosen occupied slot
    function logic [STAMP_W-1:0] pick_live();
      int k;
      k = $urandom_range(0, live_slots() - 1);
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_count[i] != 0) begin
          if (k == 0) return slot_stamp[i];
          k--;
        end
      end
      return '0;
    endfunction

    // Minimum live read stamp, or the commit stamp when nothing is live
    function void refresh_watermark();
      logic               found;
      logic [STAMP_W-1:0] lowest;
      found  = 1'b0;
      lowest = commit_stamp;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_count[i] != 0 && (!found || slot_stamp[i] < lowest)) begin
          lowest = slot_stamp[i];
          found  = 1'b1;
        end
      end
      watermark = lowest;
    endfunction

    // Apply one accepted item; returns 1 when it changed the tracked state
    function bit note_request(op_t op, logic [STAMP_W-1:0] stamp);
      status_t status;
      int      slot;
      bit      changed;
      status  = ST_OK;
      changed = 1'b0;
      case (op)
        OP_ADD: begin
          slot = find_stamp(stamp);
          if (slot >= 0) begin
            if (slot_count[slot] == {COUNT_BITS{1'b1}}) begin
              status = ST_OVERFLOW;
            end else begin
              slot_count[slot] = slot_count[slot] + 1'b1;
              changed = 1'b1;
            end
          end else begin
            slot = first_free();
            if (slot < 0) begin
              status = ST_FULL;
            end else begin
              slot_stamp[slot] = stamp;
              slot_count[slot] = COUNT_BITS'(1);
              changed = 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          slot = find_stamp(stamp);
          if (slot < 0) begin
            status = ST_ABSENT;
          end else begin
            slot_count[slot] = slot_count[slot] - 1'b1;
            changed = 1'b1;
          end
        end
        OP_UPDATE: begin
          commit_stamp = stamp;
          changed = 1'b1;
        end
        default: ;
      endcase
      if (changed) refresh_watermark();
      expected_q.push_back('{watermark, status});
      return changed;
    endfunction

    function void check_response(logic [STAMP_W-1:0] wm, logic [1:0] status);
      tracker_result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result watermark %h status %0d", $time, wm, status);
        return;
      end
      exp = expected_q.pop_front();
      if (exp.watermark !== wm || exp.status !== status) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: mismatch: expected watermark %h status %0d, got watermark %h status %0d",
                   $time, exp.watermark, exp.status, wm, status);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rwt_req_if req();
  rwt_rsp_if rsp();

  read_timestamp_watermark_tracker_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  watermark_scoreboard sb;
  bit                  idle_on;
  int unsigned         cycles;
  int                  stall_left;

  always #(CLK_HALF) clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Check every result item the block hands over
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_response(rsp.watermark, rsp.status);
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  task automatic send_item(op_t op, logic [STAMP_W-1:0] stamp, output bit changed);
    @(negedge clk);
    req.valid     <= 1'b1;
    req.operation <= op;
    req.stamp     <= stamp;
    do @(posedge clk); while (!req.ready);
    changed = sb.note_request(op, stamp);
  endtask

  task automatic sender_gap();
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drive(op_t op, logic [STAMP_W-1:0] stamp);
    bit changed;
    send_item(op, stamp, changed);
    sender_gap();
  endtask

  // Hold the request side until every owed result has come back
  task automatic wait_drained();
    @(negedge clk);
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [STAMP_W-1:0] fresh_stamp();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 63);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 63);
      default: return $urandom;
    endcase
  endfunction

  // Mostly add/remove on live or fresh stamps, with absent removes, commits and no-ops
  task automatic random_item();
    int                 r;
    op_t                op;
    logic [STAMP_W-1:0] stamp;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      op    = OP_ADD;
      stamp = (sb.live_slots() > 0 && $urandom_range(0, 1)) ? sb.pick_live() : fresh_stamp();
    end else if (r < 75) begin
      op    = OP_REMOVE;
      stamp = (sb.live_slots() > 0 && $urandom_range(0, 9) < 8) ? sb.pick_live()
                                                              : fresh_stamp();
    end else if (r < 93) begin
      op    = OP_UPDATE;
      stamp = fresh_stamp();
    end else begin
      op    = OP_NOP;
      stamp = $urandom;
    end
    drive(op, stamp);
  endtask

  initial begin
    int sent;

    sb            = new();
    idle_on       = 1'b0;
    stall_left    = 0;
    cycles        = 0;
    req.valid     = 1'b0;
    req.operation = OP_ADD;
    req.stamp     = '0;
    rsp.ready     = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // Empty table: absent remove, commit moves watermark, no-op
    drive(OP_REMOVE, 32'h0000_0000);
    drive(OP_UPDATE, 32'hFFFF_FFFF);
    drive(OP_NOP,    32'h0000_0005);
    // Extremes of the stamp, commit while reads are live
    drive(OP_ADD,    32'hFFFF_FFFF);
    drive(OP_ADD,    32'h0000_0000);
    drive(OP_UPDATE, 32'h1234_5678);
    drive(OP_REMOVE, 32'h0000_0000);
    drive(OP_REMOVE, 32'hFFFF_FFFF);
    drive(OP_REMOVE, 32'hFFFF_FFFF);
    // Fill every slot with a falling stamp, then hit the full table
    for (int i = 0; i < ENTRIES; i++)
      drive(OP_ADD, 32'hF000_0000 - i * 32'h0F0F_0F0F);
    drive(OP_ADD, 32'h5555_5555);
    drive(OP_ADD, 32'hF000_0000);
    wait_drained();

    // Random traffic; every third chunk of 100 runs without idling
    sent = 0;
    while (sent < RANDOM_ITEMS - CALM_ITEMS) begin
      idle_on = ((sent / 100) % 3 != 2);
      random_item();
      sent++;
      if (sent % DRAIN_PERIOD == 0) wait_drained();
    end
    idle_on = 1'b0;
    wait_drained();

    // Final stretch with no idling on either side
    while (sent < RANDOM_ITEMS) begin
      random_item();
      sent++;
    end

    @(negedge clk);
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
